>>> sv/hc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher stream.
// No dependencies; every other source file but hc_in_if uses this package.
package hc_pkg;

  localparam int unsigned MOD          = 26;
  localparam int unsigned MOD_SQ       = MOD * MOD;
  localparam int unsigned PAD_CODE     = 23;       // 'X'
  localparam int unsigned RECIP26      = 2521;     // ceil(2^16 / 26)
  localparam int unsigned RECIP_SHIFT  = 16;
  localparam int unsigned SETTLE       = 8;        // key pipeline depth
  localparam int unsigned SETTLE_W     = $clog2(SETTLE + 1);
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] ASC_UP_A = 8'h41;
  localparam logic [7:0] ASC_UP_Z = 8'h5A;
  localparam logic [7:0] ASC_LO_A = 8'h61;
  localparam logic [7:0] ASC_LO_Z = 8'h7A;

  typedef logic [4:0]  letter_t;
  typedef logic [5:0]  quot_t;
  typedef logic [9:0]  prod_t;
  typedef logic [10:0] wide_t;

  typedef enum logic [1:0] {
    STAT_LETTER = 2'd0,
    STAT_END    = 2'd1,
    STAT_ODD    = 2'd2,
    STAT_BADKEY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_KEY_A   = 3'd0,
    CFG_KEY_B   = 3'd1,
    CFG_KEY_C   = 3'd2,
    CFG_KEY_D   = 3'd3,
    CFG_DECRYPT = 3'd4
  } cfg_idx_e;

  // One unit of work for the back end. kind STAT_LETTER means a letter pair.
  typedef struct packed {
    status_e kind;
    letter_t first;
    letter_t second;
    logic    last;
  } job_t;

  typedef struct packed {
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
  } key_t;

  typedef struct packed {
    logic ok;       // determinant coprime with 26
    logic ready;    // derived key values have settled
    logic decrypt;
  } key_stat_t;

  function automatic letter_t red26(input letter_t v);
    return (v >= letter_t'(MOD)) ? v - letter_t'(MOD) : v;
  endfunction

  // floor(x / 26), exact for x below 1664
  function automatic quot_t div26(input wide_t x);
    logic [22:0] p;
    p = 23'(x) * 23'(RECIP26);
    return p[RECIP_SHIFT +: 6];
  endfunction

  function automatic letter_t rem26(input wide_t x, input quot_t q);
    wide_t t;
    t = x - wide_t'(q) * wide_t'(MOD);
    return t[4:0];
  endfunction

  function automatic letter_t inv26(input letter_t v);
    letter_t r;
    unique case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/hc_in_if.sv
`timescale 1ns / 1ps
// Input channel: one text byte per word plus the end-of-message flag.
// No dependencies.
interface hc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       message_end;

  modport source (output valid, output symbol, output message_end, input ready);
  modport sink   (input valid, input symbol, input message_end, output ready);
endinterface

>>> sv/hc_out_if.sv
`timescale 1ns / 1ps
// Output channel: one result letter or status word per handshake.
// Uses hc_pkg for the letter type.
interface hc_out_if;
  logic            valid;
  logic            ready;
  hc_pkg::letter_t letter_code;
  logic [1:0]      status;
  logic            final_result;

  modport source (output valid, output letter_code, output status, output final_result,
                  input ready);
  modport sink   (input valid, input letter_code, input status, input final_result,
                  output ready);
endinterface

>>> sv/hc_key.sv
`timescale 1ns / 1ps
// Configuration registers and the pipeline that derives the working matrix.
// Depends on hc_pkg.
module hc_key (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [4:0]          cfg_data_i,
  output hc_pkg::key_t        key_o,
  output hc_pkg::key_stat_t   stat_o
);
  import hc_pkg::*;

  letter_t             key_q [4];   // a, b, c, d
  logic                dec_q;
  logic [SETTLE_W-1:0] settle_q;

  letter_t red_q [4];
  prod_t   ad_q, bc_q;
  wide_t   diff_q;
  quot_t   dq_q;
  letter_t inv_q;
  logic    ok_q;
  prod_t   np_q [4];
  quot_t   nq_q [4];
  key_t    m_q;

  letter_t det;
  letter_t num [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= 5'd3;
      key_q[1] <= 5'd3;
      key_q[2] <= 5'd2;
      key_q[3] <= 5'd5;
      dec_q    <= 1'b0;
      settle_q <= SETTLE_W'(SETTLE);
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE);
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_KEY_A:   key_q[0] <= cfg_data_i;
          CFG_KEY_B:   key_q[1] <= cfg_data_i;
          CFG_KEY_C:   key_q[2] <= cfg_data_i;
          CFG_KEY_D:   key_q[3] <= cfg_data_i;
          CFG_DECRYPT: dec_q    <= cfg_data_i[0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  assign det    = rem26(diff_q, dq_q);
  assign num[0] = red_q[3];
  assign num[1] = letter_t'(MOD) - red_q[1];
  assign num[2] = letter_t'(MOD) - red_q[2];
  assign num[3] = red_q[0];

  // det = (ad - bc) mod 26, inverse by table, inverse matrix = inv * adj
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      red_q[i] <= red26(key_q[i]);
      np_q[i]  <= prod_t'(num[i]) * prod_t'(inv_q);
      nq_q[i]  <= div26(wide_t'(np_q[i]));
    end
    ad_q   <= prod_t'(red_q[0]) * prod_t'(red_q[3]);
    bc_q   <= prod_t'(red_q[1]) * prod_t'(red_q[2]);
    diff_q <= wide_t'(ad_q) + wide_t'(MOD_SQ) - wide_t'(bc_q);
    dq_q   <= div26(diff_q);
    inv_q  <= inv26(det);
    ok_q   <= (inv26(det) != '0);
    if (dec_q) begin
      m_q.m00 <= rem26(wide_t'(np_q[0]), nq_q[0]);
      m_q.m01 <= rem26(wide_t'(np_q[1]), nq_q[1]);
      m_q.m10 <= rem26(wide_t'(np_q[2]), nq_q[2]);
      m_q.m11 <= rem26(wide_t'(np_q[3]), nq_q[3]);
    end else begin
      m_q.m00 <= red_q[0];
      m_q.m01 <= red_q[1];
      m_q.m10 <= red_q[2];
      m_q.m11 <= red_q[3];
    end
  end

  assign key_o          = m_q;
  assign stat_o.ok      = ok_q;
  assign stat_o.ready   = (settle_q == '0);
  assign stat_o.decrypt = dec_q;

endmodule

>>> sv/hc_front.sv
`timescale 1ns / 1ps
// Front end: accepts text words, filters and pairs letters, issues jobs.
// Depends on hc_pkg and hc_in_if.
module hc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  hc_in_if.sink             in_i,
  input  hc_pkg::key_stat_t key_stat_i,
  input  logic              full_i,
  output logic              push_o,
  output hc_pkg::job_t      job_o
);
  import hc_pkg::*;

  logic    holding_q, holding_d;
  letter_t held_q, held_d;
  logic    is_up, is_lo, is_letter, acc, last, pair, want;
  letter_t code;
  logic [7:0] off;

  assign in_i.ready = key_stat_i.ready && !full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign last       = in_i.message_end;

  assign is_up     = (in_i.symbol >= ASC_UP_A) && (in_i.symbol <= ASC_UP_Z);
  assign is_lo     = (in_i.symbol >= ASC_LO_A) && (in_i.symbol <= ASC_LO_Z);
  assign is_letter = is_up || is_lo;
  assign off       = in_i.symbol - (is_up ? ASC_UP_A : ASC_LO_A);
  assign code      = off[4:0];

  always_comb begin
    holding_d    = holding_q;
    held_d       = held_q;
    pair         = 1'b0;
    want         = 1'b0;
    job_o.kind   = STAT_LETTER;
    job_o.second = code;
    job_o.last   = last;

    if (is_letter) begin
      if (holding_q) begin
        pair      = 1'b1;
        holding_d = 1'b0;
      end else begin
        held_d    = code;
        holding_d = 1'b1;
      end
    end

    if (!key_stat_i.ok) begin
      // bad key: pairs still form, only the end of message reports
      pair = 1'b0;
      if (last) begin
        want       = 1'b1;
        job_o.kind = STAT_BADKEY;
      end
    end else begin
      if (!pair && last && holding_d) begin
        if (key_stat_i.decrypt) begin
          want       = 1'b1;
          job_o.kind = STAT_ODD;
        end else begin
          pair         = 1'b1;
          job_o.second = letter_t'(PAD_CODE);
        end
      end
      if (pair) begin
        want = 1'b1;
      end else if (last && !want) begin
        want       = 1'b1;
        job_o.kind = STAT_END;
      end
    end
    if (last) holding_d = 1'b0;
    job_o.first = held_d;
  end

  assign push_o = acc && want;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
      held_q    <= '0;
    end else if (acc) begin
      holding_q <= holding_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> sv/hc_fifo.sv
`timescale 1ns / 1ps
// Short job queue between front and back ends.
// Depends on hc_pkg.
module hc_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hc_pkg::job_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output hc_pkg::job_t data_o,
  output logic         valid_o
);
  import hc_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/hc_back.sv
`timescale 1ns / 1ps
// Back end: expands jobs into result words and does the matrix math mod 26.
// Depends on hc_pkg and hc_out_if.
module hc_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hc_pkg::job_t job_i,
  input  logic         job_valid_i,
  output logic         pop_o,
  input  hc_pkg::key_t key_i,
  hc_out_if.source     out_o
);
  import hc_pkg::*;

  logic    en, is_pair, phase_q;
  letter_t ma, mb;

  logic    v1_q, v2_q, v3_q, vo_q;
  prod_t   p0_q, p1_q;
  wide_t   s2_q, s3_q;
  quot_t   q3_q;
  letter_t lo_q;
  status_e st1_q, st2_q, st3_q, sto_q;
  logic    f1_q, f2_q, f3_q, fo_q;

  // whole pipe stalls while the output word waits
  assign en      = !vo_q || out_o.ready;
  assign is_pair = (job_i.kind == STAT_LETTER);
  assign pop_o   = en && job_valid_i && (!is_pair || phase_q);
  assign ma      = phase_q ? key_i.m10 : key_i.m00;
  assign mb      = phase_q ? key_i.m11 : key_i.m01;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else if (en) begin
      if (job_valid_i && is_pair) phase_q <= !phase_q;
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (is_pair) begin
        p0_q  <= prod_t'(ma) * prod_t'(job_i.first);
        p1_q  <= prod_t'(mb) * prod_t'(job_i.second);
        st1_q <= STAT_LETTER;
        f1_q  <= phase_q && job_i.last;
      end else begin
        p0_q  <= '0;
        p1_q  <= '0;
        st1_q <= job_i.kind;
        f1_q  <= 1'b1;
      end
      s2_q  <= wide_t'(p0_q) + wide_t'(p1_q);
      st2_q <= st1_q;
      f2_q  <= f1_q;
      s3_q  <= s2_q;
      q3_q  <= div26(s2_q);
      st3_q <= st2_q;
      f3_q  <= f2_q;
      lo_q  <= rem26(s3_q, q3_q);
      sto_q <= st3_q;
      fo_q  <= f3_q;
    end
  end

  assign out_o.valid        = vo_q;
  assign out_o.letter_code  = lo_q;
  assign out_o.status       = sto_q;
  assign out_o.final_result = fo_q;

endmodule

>>> sv/hill_cipher_2x2_stream.sv
`timescale 1ns / 1ps
// Top level of the 2x2 Hill cipher (mod 26) text stream.
// Depends on hc_pkg, hc_in_if, hc_out_if, hc_key, hc_front, hc_fifo, hc_back.
//
// Takes one text byte per input word and sustains one input word per cycle
// while the job queue has room and the key has settled; the output side
// moves one result word per cycle while out ready is high, two words per
// letter pair, so the output port bounds a stream of pairs. The front end
// filters and pairs letters and drops a job into a four-entry queue; the back
// end runs each result word through a four-stage multiply / mod-26 pipeline.
// The working matrix (and its inverse for decrypt) is derived from the key
// registers by an eight-stage pipeline: after any config write, and after
// reset, in ready stays low until the settle counter has run down. Write
// config only while no word is in flight. A non-letter that causes no result
// leaves nothing behind after the cycle it is taken; the first letter of a
// pair waits in the front end. A bad key (determinant sharing a factor with
// 26) emits only status 3 at message end.
module hill_cipher_2x2_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  hc_in_if.sink      in_i,
  hc_out_if.source   out_o
);
  import hc_pkg::*;

  key_t      key;
  key_stat_t key_stat;
  job_t      push_job, head_job;
  logic      push, full, pop, head_valid;

  // config registers and derived matrix
  hc_key u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key),
    .stat_o     (key_stat)
  );

  // letter filter and pairing
  hc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .key_stat_i (key_stat),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  hc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .valid_o (head_valid)
  );

  // matrix math and result words
  hc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .pop_o       (pop),
    .key_i       (key),
    .out_o       (out_o)
  );

endmodule

>>> verif/hill_cipher_2x2_stream_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hill_cipher_2x2_stream: directed and random text words
// checked against a mod-26 letter-pair predictor held in a small scoreboard class.
// Depends on hc_pkg, hc_in_if, hc_out_if and the RTL of the block.
module hill_cipher_2x2_stream_tb;
  import hc_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned QUIET_CYCLES = 16;     // covers key settle plus the back-end pipeline
  localparam int unsigned LONG_HOLD    = 120;    // receiver hold-off, fills the job queue
  localparam int unsigned TARGET_BYTES = 430;    // minimum input words over the whole run
  localparam int unsigned CALM_BYTES   = 80;     // tail of the run with no idling
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    letter_t code;
    status_e st;
    logic    fin;
  } hill_result_t;

  // Predicts the result words of the cipher from the accepted input words and
  // compares every delivered result against the oldest prediction.
  class hill_pair_scoreboard;
    logic [4:0]   key_a, key_b, key_c, key_d;
    logic         decrypt;
    letter_t      held;
    bit           holding;
    hill_result_t pending_results[$];
    int unsigned  errors, n_letters, n_markers, n_odd, n_badkey;

    function new();
      key_a = 5'd3;
      key_b = 5'd3;
      key_c = 5'd2;
      key_d = 5'd5;
      decrypt = 1'b0;
      held = '0;
      holding = 1'b0;
      errors = 0;
      n_letters = 0;
      n_markers = 0;
      n_odd = 0;
      n_badkey = 0;
    endfunction

    // inverse of the determinant mod 26, 0 when the key cannot be inverted
    static function int unsigned det_inverse(int unsigned a, b, c, d);
      int unsigned det;
      det = ((a % MOD) * (d % MOD) + MOD_SQ - (b % MOD) * (c % MOD)) % MOD;
      for (int unsigned k = 1; k < MOD; k++)
        if ((det * k) % MOD == 1) return k;
      return 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [4:0] v);
      case (idx)
        CFG_KEY_A:   key_a = v;
        CFG_KEY_B:   key_b = v;
        CFG_KEY_C:   key_c = v;
        CFG_KEY_D:   key_d = v;
        CFG_DECRYPT: decrypt = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void push_result(int unsigned code, status_e st, logic fin);
      hill_result_t r;
      r.code = letter_t'(code);
      r.st = st;
      r.fin = fin;
      pending_results.insert(pending_results.size(), r);
      case (st)
        STAT_LETTER: n_letters++;
        STAT_END:    n_markers++;
        STAT_ODD:    n_odd++;
        default:     n_badkey++;
      endcase
    endfunction

    function void take_byte(logic [7:0] sym, logic last);
      int unsigned a, b, c, d, inv, m00, m01, m10, m11, first, second;
      letter_t     code;
      bit          is_letter, pair;
      a = key_a % MOD;
      b = key_b % MOD;
      c = key_c % MOD;
      d = key_d % MOD;
      inv = det_inverse(key_a, key_b, key_c, key_d);
      m00 = a;
      m01 = b;
      m10 = c;
      m11 = d;
      if (decrypt) begin
        m00 = (d * inv) % MOD;
        m01 = ((MOD - b) * inv) % MOD;
        m10 = ((MOD - c) * inv) % MOD;
        m11 = (a * inv) % MOD;
      end
      is_letter = 1'b0;
      pair = 1'b0;
      first = 0;
      second = 0;
      code = '0;
      if (sym >= ASC_UP_A && sym <= ASC_UP_Z) begin
        is_letter = 1'b1;
        code = letter_t'(sym - ASC_UP_A);
      end else if (sym >= ASC_LO_A && sym <= ASC_LO_Z) begin
        is_letter = 1'b1;
        code = letter_t'(sym - ASC_LO_A);
      end
      if (is_letter) begin
        if (holding) begin
          pair = 1'b1;
          first = held;
          second = code;
          holding = 1'b0;
        end else begin
          held = code;
          holding = 1'b1;
        end
      end
      // bad key: pairs still form, only the end of message reports
      if (inv == 0) begin
        if (last) begin
          push_result(0, STAT_BADKEY, 1'b1);
          holding = 1'b0;
        end
        return;
      end
      if (!pair && last && holding) begin
        holding = 1'b0;
        if (decrypt) begin
          push_result(0, STAT_ODD, 1'b1);
          return;
        end
        pair = 1'b1;
        first = held;
        second = PAD_CODE;
      end
      if (pair) begin
        push_result((m00 * first + m01 * second) % MOD, STAT_LETTER, 1'b0);
        push_result((m10 * first + m11 * second) % MOD, STAT_LETTER, last);
      end else if (last) begin
        push_result(0, STAT_END, 1'b1);
      end
      if (last) holding = 1'b0;
    endfunction

    function void check_letter(letter_t code, logic [1:0] st, logic fin);
      hill_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: letter %0d status %0d final %0b", $time, code, st,
                 fin);
        return;
      end
      exp_r = pending_results.pop_front();
      if (code !== exp_r.code) begin
        errors++;
        $display("%0t: letter_code expected %0d actual %0d", $time, exp_r.code, code);
      end
      if (st !== exp_r.st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_r.st, st);
      end
      if (fin !== exp_r.fin) begin
        errors++;
        $display("%0t: final_result expected %0b actual %0b", $time, exp_r.fin, fin);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_e   cfg_idx;
  logic [4:0] cfg_data;

  hc_in_if  in_ch();
  hc_out_if out_ch();

  hill_pair_scoreboard sb;

  // idling knobs, in percent per word / per cycle
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  bit          hold_req;          // asks the receiver for one long hold-off
  int unsigned words_sent;        // letters and message ends taken by the block
  int unsigned bytes_sent;
  int unsigned key_settings;
  int unsigned cycles;

  hill_cipher_2x2_stream dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // results are taken on the rising edge, before the block's registers move
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_letter(out_ch.letter_code, out_ch.status, out_ch.final_result);
  end

  // watchdog: a stuck handshake or a lost result ends the run here
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout, %0d results still expected", $time, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stall bursts, or one long hold-off on request. At most one
  // nonblocking write to ready per falling edge.
  initial begin : receiver
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(99) < out_stall_pct) begin
        n = $urandom_range(17, 1);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // drops valid for a pause set by n; the next word raises it on a later falling edge
  task automatic pause_input(input int unsigned n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offers one word and waits for its handshake. Valid stays high after the
  // handshake so back-to-back words never drop it within one time step.
  task automatic send_byte(input logic [7:0] sym, input logic last);
    logic [7:0] folded;
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct)
      pause_input($urandom_range(17, 1));
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.message_end <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.take_byte(sym, last);
    bytes_sent++;
    folded = sym | 8'h20;
    if (last || (folded >= ASC_LO_A && folded <= ASC_LO_Z)) words_sent++;
  endtask

  // Waits until every predicted result has arrived; with settle, also lets the
  // back end go quiet so a register write cannot land on work in flight.
  task automatic drain(input bit settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [4:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // full key load, only from idle
  task automatic reconfigure(input logic [4:0] a, b, c, d, input logic dec);
    drain(1'b1);
    write_cfg(CFG_KEY_A, a);
    write_cfg(CFG_KEY_B, b);
    write_cfg(CFG_KEY_C, c);
    write_cfg(CFG_KEY_D, d);
    write_cfg(CFG_DECRYPT, {4'b0, dec});
    key_settings++;
  endtask

  // mostly letters of either case, else any byte at all
  function automatic logic [7:0] rand_symbol(input int unsigned letter_pct);
    logic [7:0] base;
    if ($urandom_range(99) < letter_pct) begin
      base = $urandom_range(1) ? ASC_LO_A : ASC_UP_A;
      return base + 8'($urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(rand_symbol(85), 1'b0);
    send_byte(rand_symbol(60), 1'b1);
  endtask

  // random registers, values above 25 included; ok_pct biases toward keys that invert
  task automatic random_key(input int unsigned ok_pct);
    logic [4:0] k[4];
    bit         want_ok;
    want_ok = $urandom_range(99) < ok_pct;
    do begin
      foreach (k[i]) k[i] = 5'($urandom_range(31));
    end while (want_ok && hill_pair_scoreboard::det_inverse(k[0], k[1], k[2], k[3]) == 0);
    reconfigure(k[0], k[1], k[2], k[3], 1'($urandom_range(1)));
  endtask

  task automatic extreme_key();
    logic dec;
    dec = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: reconfigure(5'd0, 5'd0, 5'd0, 5'd0, dec);        // det 0
      1: reconfigure(5'd25, 5'd25, 5'd25, 5'd25, dec);    // det 0
      2: reconfigure(5'd31, 5'd31, 5'd31, 5'd31, dec);    // folds to 5s, det 0
      3: reconfigure(5'd25, 5'd0, 5'd0, 5'd25, dec);      // det 1
      4: reconfigure(5'd0, 5'd1, 5'd1, 5'd0, dec);        // swap, det 25
      default: reconfigure(5'd31, 5'd30, 5'd26, 5'd31, dec);
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase;
    bit          calm;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_KEY_A;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.symbol      = '0;
    in_ch.message_end = 1'b0;
    hold_req          = 1'b0;
    in_gap_pct        = 0;
    out_stall_pct     = 0;
    words_sent        = 0;
    bytes_sent        = 0;
    key_settings      = 1;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset key, encrypt ---
    send_byte("A", 1'b0);            // letter extremes, both cases
    send_byte("z", 1'b0);
    send_byte(8'h40, 1'b0);          // bytes just outside the letter ranges
    send_byte("a", 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte("Z", 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h20, 1'b1);          // message end with nothing pending
    send_byte("H", 1'b0);
    send_byte("I", 1'b0);
    send_byte("J", 1'b1);            // odd leftover, padded with X
    send_byte("k", 1'b0);
    send_byte("L", 1'b1);            // end word closes a pair

    // decrypt with the same key: pair, odd leftover error
    reconfigure(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
    send_byte("A", 1'b0);
    send_byte("B", 1'b0);
    send_byte("C", 1'b1);

    // key that cannot be inverted: only the end of message reports
    reconfigure(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
    send_byte("A", 1'b0);
    send_byte("B", 1'b0);
    send_byte("C", 1'b1);

    // registers above 25 fold before use
    reconfigure(5'd31, 5'd26, 5'd27, 5'd29, 1'b1);
    send_byte("M", 1'b0);
    send_byte("n", 1'b1);
    reconfigure(5'd25, 5'd0, 5'd0, 5'd25, 1'b0);
    send_byte("Y", 1'b1);

    // --- random phases: a key setting, then a handful of messages ---
    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      calm = (bytes_sent + CALM_BYTES >= TARGET_BYTES);
      if (phase == 1) random_key(100);
      else if (phase % 4 == 0) extreme_key();
      else random_key(75);

      if (calm) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        case ($urandom_range(2))
          0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
          1: begin in_gap_pct = 10; out_stall_pct = 10; end
          default: begin in_gap_pct = 30; out_stall_pct = 25; end
        endcase
      end

      if (phase == 1) begin
        // receiver holds off while the sender keeps offering: queue fills, input stalls
        in_gap_pct = 0;
        hold_req = 1'b1;
        send_message(24);
      end
      if (phase == 2) begin
        send_message($urandom_range(9, 2));
        drain(1'b0);                 // sender pause until every result is back
      end

      repeat ($urandom_range(6, 3)) send_message($urandom_range(9));
      // sometimes leave a letter held across the next key change
      if ($urandom_range(1)) send_byte(rand_symbol(100), 1'b0);
      phase++;
    end

    drain(1'b1);
    $display("Covered %0d words (%0d bytes) over %0d key settings: %0d letters, %0d end",
             words_sent, bytes_sent, key_settings, sb.n_letters, sb.n_markers);
    $display("markers, %0d odd-length errors, %0d bad-key reports; %0d field mismatches",
             sb.n_odd, sb.n_badkey, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/hc_pkg.sv
sv/hc_in_if.sv
sv/hc_out_if.sv
sv/hc_key.sv
sv/hc_front.sv
sv/hc_fifo.sv
sv/hc_back.sv
sv/hill_cipher_2x2_stream.sv
verif/hill_cipher_2x2_stream_tb.sv
